// ===== sv/sar_pkg.sv =====
// ----------------------------------------------------------------------------
// sar_pkg - servo angle ramp shared definitions
// Item kinds, angle and speed limits, and the step interval table.
// ----------------------------------------------------------------------------
package sar_pkg;

	// Item kinds carried on the slave-side tuser
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_SWEEP = 2'd2;

	localparam int ANGLE_W = 8;
	localparam int SPEED_W = 4;
	localparam int COUNT_W = 5;

	localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;
	localparam logic [ANGLE_W-1:0] ANGLE_RST  = 8'd90;
	localparam logic [SPEED_W-1:0] SPEED_MIN  = 4'd1;
	localparam logic [SPEED_W-1:0] SPEED_MAX  = 4'd10;
	localparam logic [SPEED_W-1:0] SPEED_RST  = 4'd5;
	localparam logic [SPEED_W-1:0] FAST_SPEED = 4'd5;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 5'd31;

	// Step interval in ms: floor(20 - 1.5 * speed), held for out-of-range codes
	function automatic logic [COUNT_W-1:0] step_interval(input logic [SPEED_W-1:0] spd);
		logic [COUNT_W-1:0] ivl;
		case (spd)
			4'd0:    ivl = 5'd18;
			4'd1:    ivl = 5'd18;
			4'd2:    ivl = 5'd17;
			4'd3:    ivl = 5'd15;
			4'd4:    ivl = 5'd14;
			4'd5:    ivl = 5'd12;
			4'd6:    ivl = 5'd11;
			4'd7:    ivl = 5'd9;
			4'd8:    ivl = 5'd8;
			4'd9:    ivl = 5'd6;
			default: ivl = 5'd5;
		endcase
		return ivl;
	endfunction

endpackage

// ===== sv/servo_angle_ramp_top.sv =====
// ----------------------------------------------------------------------------
// servo_angle_ramp_top - servo slew-rate limiter
// Steps a servo angle toward a target on millisecond ticks; set and sweep
// commands load the angle, target and speed. One result per transaction.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                        tuser
//  s_*       in   angle[7:0], speed[15:8]                   mode[1:0]
//  m_*       out  servo_angle[7:0], sweeping[8],            -
//                 angle_written[9], zero[15:10]
//
// Each transaction is held in the input register until it can move into the
// output register; one transaction per cycle is sustained while m_tready is high.
// The ramp state updates as an item leaves the input register, so state and
// results stay in transaction order. A stalled output holds the input stage,
// which then drops s_tready. Reset clears the angle and target to 90, speed
// to 5, the sweep flag and the millisecond counter.
// ----------------------------------------------------------------------------
module servo_angle_ramp_top
	import sar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // angle[7:0], speed[15:8]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // servo_angle[7:0], sweeping[8], angle_written[9]
);

	// Input register
	logic               vld_s1;
	logic [1:0]         mode_s1;
	logic [ANGLE_W-1:0] angle_s1;
	logic [7:0]         speed_s1;

	// Ramp state
	logic [ANGLE_W-1:0] now_q;
	logic [ANGLE_W-1:0] goal_q;
	logic [SPEED_W-1:0] rate_q;
	logic               motion_q;
	logic [COUNT_W-1:0] cnt_q;

	// Output register
	logic               out_vld_q;
	logic [ANGLE_W-1:0] out_angle_q;
	logic               out_sweep_q;
	logic               out_wrote_q;

	// Next-state logic
	logic               advance;
	logic [ANGLE_W-1:0] angle_clamp;
	logic [SPEED_W-1:0] speed_clamp;
	logic [COUNT_W-1:0] cnt_inc;
	logic [ANGLE_W-1:0] step;
	logic [ANGLE_W-1:0] gap_up;
	logic [ANGLE_W-1:0] gap_dn;
	logic [ANGLE_W-1:0] now_d;
	logic [ANGLE_W-1:0] goal_d;
	logic [SPEED_W-1:0] rate_d;
	logic               motion_d;
	logic [COUNT_W-1:0] cnt_d;
	logic               wrote_d;

	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1  <= s_tuser;
			angle_s1 <= s_tdata[7:0];
			speed_s1 <= s_tdata[15:8];
		end
	end

	// Clamp the request and work out the next ramp state
	always_comb begin
		angle_clamp = (angle_s1 > ANGLE_MAX) ? ANGLE_MAX : angle_s1;
		if (speed_s1 == 8'd0) begin
			speed_clamp = SPEED_MIN;
		end else if (speed_s1 > {4'd0, SPEED_MAX}) begin
			speed_clamp = SPEED_MAX;
		end else begin
			speed_clamp = speed_s1[SPEED_W-1:0];
		end
		cnt_inc = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + 1'b1;
		step    = (rate_q > FAST_SPEED) ? 8'd2 : 8'd1;
		gap_up  = goal_q - now_q;
		gap_dn  = now_q - goal_q;

		now_d    = now_q;
		goal_d   = goal_q;
		rate_d   = rate_q;
		motion_d = motion_q;
		cnt_d    = cnt_q;
		wrote_d  = 1'b0;

		case (mode_s1)
			MODE_TICK: begin
				cnt_d = cnt_inc;
				if (motion_q && (cnt_inc >= step_interval(rate_q))) begin
					cnt_d = '0;
					if (now_q < goal_q) begin
						now_d   = (gap_up <= step) ? goal_q : now_q + step;
						wrote_d = 1'b1;
					end else if (now_q > goal_q) begin
						now_d   = (gap_dn <= step) ? goal_q : now_q - step;
						wrote_d = 1'b1;
					end else begin
						// Arrived: end the sweep
						motion_d = 1'b0;
					end
				end
			end
			MODE_SET: begin
				now_d    = angle_clamp;
				goal_d   = angle_clamp;
				motion_d = 1'b0;
				wrote_d  = 1'b1;
			end
			MODE_SWEEP: begin
				if (angle_clamp != now_q) begin
					goal_d   = angle_clamp;
					rate_d   = speed_clamp;
					motion_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Commit the ramp state as the transaction moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= ANGLE_RST;
			goal_q   <= ANGLE_RST;
			rate_q   <= SPEED_RST;
			motion_q <= 1'b0;
			cnt_q    <= '0;
		end else if (advance) begin
			now_q    <= now_d;
			goal_q   <= goal_d;
			rate_q   <= rate_d;
			motion_q <= motion_d;
			cnt_q    <= cnt_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_angle_q <= now_d;
			out_sweep_q <= motion_d;
			out_wrote_q <= wrote_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, out_wrote_q, out_sweep_q, out_angle_q};

endmodule

// ===== tb/sv/servo_angle_ramp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_angle_ramp_checker - result checker for the servo angle ramp
// Watches both stream channels. Each accepted input transaction runs through
// a local model of the ramp (angle, target, speed, sweep flag, ms counter).
// The model's report is queued and compared field by field with the next
// output transaction.
// ----------------------------------------------------------------------------
module servo_angle_ramp_checker
	import sar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // angle[7:0], speed[15:8]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // servo_angle[7:0], sweeping[8], angle_written[9]
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [ANGLE_W-1:0] servo_angle;
		logic               sweeping;
		logic               angle_written;
	} angle_report_t;

	// Ticks between steps, floor(20 - 1.5 * speed), held for out-of-range codes, indexed by speed
	localparam logic [COUNT_W-1:0] DUE_MS [0:15] = '{
		5'd18, 5'd18, 5'd17, 5'd15, 5'd14, 5'd12, 5'd11, 5'd9,
		5'd8,  5'd6,  5'd5,  5'd5,  5'd5,  5'd5,  5'd5,  5'd5
	};

	// Local copy of the ramp state
	logic [ANGLE_W-1:0] cur_angle;
	logic [ANGLE_W-1:0] goal_angle;
	logic [SPEED_W-1:0] rate;
	logic               moving;
	logic [COUNT_W-1:0] ms_count;

	angle_report_t reports_due[$];

	// Apply one item to the local ramp state and return the report it causes
	function automatic angle_report_t ramp_after_item(input logic [1:0] mode,
			input logic [7:0] req_angle, input logic [7:0] req_speed);
		angle_report_t      rep;
		logic [ANGLE_W-1:0] ang;
		logic [SPEED_W-1:0] spd;
		logic [ANGLE_W-1:0] stride;
		logic [ANGLE_W-1:0] gap;
		logic               wrote;
		ang = (req_angle > ANGLE_MAX) ? ANGLE_MAX : req_angle;
		wrote = 1'b0;
		case (mode)
			MODE_TICK: begin
				if (ms_count != COUNT_MAX)
					ms_count = ms_count + 1'b1;
				if (moving && ms_count >= DUE_MS[rate]) begin
					ms_count = '0;
					stride = (rate > FAST_SPEED) ? 8'd2 : 8'd1;
					if (cur_angle < goal_angle) begin
						gap = goal_angle - cur_angle;
						cur_angle = (gap <= stride) ? goal_angle : cur_angle + stride;
						wrote = 1'b1;
					end else if (cur_angle > goal_angle) begin
						gap = cur_angle - goal_angle;
						cur_angle = (gap <= stride) ? goal_angle : cur_angle - stride;
						wrote = 1'b1;
					end else begin
						// due step already on target: sweep is over
						moving = 1'b0;
					end
				end
			end
			MODE_SET: begin
				cur_angle = ang;
				goal_angle = ang;
				moving = 1'b0;
				wrote = 1'b1;
			end
			MODE_SWEEP: begin
				if (req_speed < SPEED_MIN)
					spd = SPEED_MIN;
				else if (req_speed > SPEED_MAX)
					spd = SPEED_MAX;
				else
					spd = req_speed[SPEED_W-1:0];
				// sweep to the current angle leaves everything alone
				if (ang != cur_angle) begin
					goal_angle = ang;
					rate = spd;
					moving = 1'b1;
				end
			end
			default: begin
			end
		endcase
		rep.servo_angle = cur_angle;
		rep.sweeping = moving;
		rep.angle_written = wrote;
		return rep;
	endfunction

	// Compare output transactions, then queue predictions for input ones
	always @(posedge clk or negedge arst_n) begin : watch_channels
		angle_report_t want;
		angle_report_t seen;
		if (!arst_n) begin
			cur_angle = ANGLE_RST;
			goal_angle = ANGLE_RST;
			rate = SPEED_RST;
			moving = 1'b0;
			ms_count = '0;
			reports_due.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.servo_angle = m_tdata[7:0];
				seen.sweeping = m_tdata[8];
				seen.angle_written = m_tdata[9];
				if (reports_due.size() == 0) begin
					$error("result with no expectation: servo_angle %0d", seen.servo_angle);
					mismatches++;
				end else begin
					want = reports_due.pop_front();
					if (seen.servo_angle !== want.servo_angle) begin
						$error("servo_angle: expected %0d, got %0d",
							want.servo_angle, seen.servo_angle);
						mismatches++;
					end
					if (seen.sweeping !== want.sweeping) begin
						$error("sweeping: expected %0d, got %0d", want.sweeping, seen.sweeping);
						mismatches++;
					end
					if (seen.angle_written !== want.angle_written) begin
						$error("angle_written: expected %0d, got %0d",
							want.angle_written, seen.angle_written);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				reports_due.push_back(ramp_after_item(s_tuser, s_tdata[7:0], s_tdata[15:8]));
			outstanding <= reports_due.size();
		end
	end

endmodule

// ===== tb/sv/tb_servo_angle_ramp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_angle_ramp_top - stimulus for the servo angle ramp
// Drives a directed opening (clamps, ignored sweeps, unused mode, steps near
// the target), then random scenes: set an angle, sweep near it at a random
// speed and run millisecond ticks, with stray commands mixed in. Both sides
// idle in random bursts; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_servo_angle_ramp_top
	import sar_pkg::*;
();

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1350;
	localparam int QUIET_FROM  = 1200;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = MODE_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	int mismatches;
	int outstanding;
	int items_sent = 0;
	int cycles = 0;
	int sink_stall = 0;
	bit quiet = 1'b0;
	bit calm = 1'b0;

	servo_angle_ramp_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	servo_angle_ramp_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_servo_angle_ramp_top: done, errors");
			$finish;
		end
	end

	// Stall the output side in random bursts
	always @(posedge clk) begin
		if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
			m_tready <= 1'b0;
		end else if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
			sink_stall <= $urandom_range(0, 11);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Present one transaction, with an occasional idle burst ahead of it
	task automatic send_item(input logic [1:0] mode, input logic [7:0] ang,
			input logic [7:0] spd);
		int gap_len;
		if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
			gap_len = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap_len) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {spd, ang};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (items_sent >= QUIET_FROM)
			quiet = 1'b1;
	endtask

	// Hold the input side until every queued report has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_angle();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return ANGLE_MAX;
			2: return 8'($urandom_range(181, 255));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_speed();
		case ($urandom_range(0, 9))
			0, 1: return 8'($urandom);
			2, 3: return 8'($urandom_range(0, 15));
			default: return 8'($urandom_range(1, 10));
		endcase
	endfunction

	// Target a few degrees either side of an angle, now and then anywhere
	function automatic logic [7:0] near_angle(input int center);
		int t;
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom);
		t = center + int'($urandom_range(0, 24)) - 12;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return 8'(t);
	endfunction

	initial begin : stimulus
		int scene;
		int base;
		int goal;
		int n_ticks;
		int roll;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: clamps, ignored sweeps, unused mode, a step near the target
		send_item(MODE_SET, 8'd255, 8'd0);
		send_item(MODE_SET, 8'd0, 8'd255);
		send_item(MODE_SWEEP, 8'd0, 8'd7);
		send_item(MODE_UNUSED, 8'hFF, 8'hFF);
		send_item(MODE_SWEEP, 8'd3, 8'd255);
		repeat (5) send_item(MODE_TICK, 8'h00, 8'h00);
		send_item(MODE_SWEEP, 8'd3, 8'd0);
		send_item(MODE_TICK, 8'hFF, 8'hFF);
		send_item(MODE_SWEEP, 8'd180, 8'd1);
		send_item(MODE_SET, 8'd180, 8'd5);
		send_item(MODE_SWEEP, 8'd255, 8'd6);
		send_item(MODE_TICK, 8'h5A, 8'hA5);
		send_item(MODE_SET, 8'd90, 8'd10);
		drain();

		// Random scenes
		scene = 0;
		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 3) == 0);
			base = int'(pick_angle());
			send_item(MODE_SET, 8'(base), 8'($urandom));
			if (base > ANGLE_MAX)
				base = ANGLE_MAX;
			// let the counter saturate before some sweeps
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(20, 40)) send_item(MODE_TICK, 8'($urandom), 8'($urandom));
			goal = int'(near_angle(base));
			send_item(MODE_SWEEP, 8'(goal), pick_speed());
			n_ticks = $urandom_range(8, 90);
			for (int i = 0; i < n_ticks; i++) begin
				roll = $urandom_range(0, 49);
				if (roll == 0)
					send_item(MODE_SWEEP, near_angle(goal), pick_speed());
				else if (roll == 1)
					send_item(MODE_SET, pick_angle(), 8'($urandom));
				else if (roll == 2)
					send_item(MODE_UNUSED, 8'($urandom), 8'($urandom));
				else
					send_item(MODE_TICK, 8'($urandom), 8'($urandom));
			end
			if (scene == 2 || $urandom_range(0, 7) == 0)
				drain();
			scene++;
		end

		// Wind down and report
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_servo_angle_ramp_top: done, clean");
		else
			$display("tb_servo_angle_ramp_top: done, errors");
		$finish;
	end

endmodule
